// ===== hdl/atf_pkg.sv =====
// Package with the shared types and codes of the affine tile fetch unit.
`default_nettype none

package atf_pkg;

    // Operation kinds carried in tuser.
    localparam logic [1:0] KIND_FETCH  = 2'd0;
    localparam logic [1:0] KIND_NIBBLE = 2'd1;
    localparam logic [1:0] KIND_MASKED = 2'd2;

    // Masked write selections.
    localparam logic [1:0] MASK_FULL = 2'd0;
    localparam logic [1:0] MASK_HIGH = 2'd1;
    localparam logic [1:0] MASK_LOW  = 2'd2;

    // Address mode in which the affine fetch is active.
    localparam logic [1:0] ADDR_MODE_AFFINE = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ADDRESS_MODE       = 3'd0;
    localparam logic [2:0] CFG_FOUR_BIT_MODE      = 3'd1;
    localparam logic [2:0] CFG_TRANSPARENT_WRITES = 3'd2;
    localparam logic [2:0] CFG_AFFINE_CLIP        = 3'd3;
    localparam logic [2:0] CFG_MAP_SIZE_TILES     = 3'd4;
    localparam logic [2:0] CFG_MAP_BASE           = 3'd5;
    localparam logic [2:0] CFG_TILE_BASE          = 3'd6;

    // Configuration register file.
    typedef struct packed {
        logic [1:0]  address_mode;
        logic        four_bit_mode;
        logic        transparent_writes;
        logic        affine_clip;
        logic [7:0]  map_size_tiles;
        logic [16:0] map_base;
        logic [16:0] tile_base;
    } t_cfg;

    // Coordinate split of one fetch.
    typedef struct packed {
        logic       outside;
        logic [5:0] sub;
        logic       nibble;
    } t_plan;

    // Payload of one write.
    typedef struct packed {
        logic       low_nibble;
        logic [7:0] value;
        logic [1:0] mask;
    } t_wreq;

endpackage

`default_nettype wire

// ===== hdl/atf_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module atf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 131072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/atf_addr.sv =====
// Address unit: splits fetch coordinates and forms map and tile addresses.
`default_nettype none

module atf_addr #(
    parameter int ADDR_BITS = 17
) (
    input  wire atf_pkg::t_cfg         i_cfg,
    input  wire logic [10:0]           i_x_pixel,
    input  wire logic [10:0]           i_y_pixel,
    input  wire logic [7:0]            i_tile,
    input  wire logic [5:0]            i_sub,
    output atf_pkg::t_plan             o_plan,
    output logic      [ADDR_BITS-1:0]  o_first_addr,
    output logic      [ADDR_BITS-1:0]  o_tile_addr
);

    logic [7:0]  xt;
    logic [7:0]  yt;
    logic [7:0]  wrap_mask;
    logic [5:0]  sub;
    logic        outside;
    logic [15:0] row_offset;
    logic [31:0] map_sum;
    logic [31:0] clip_sum;
    logic [31:0] tile_sum;
    logic [13:0] tile_offset;

    // Tile indices, wrapped to the map size unless clipping is on.
    always_comb begin
        wrap_mask = i_cfg.map_size_tiles - 8'd1;
        xt = i_x_pixel[10:3];
        yt = i_y_pixel[10:3];
        if (!i_cfg.affine_clip) begin
            xt = xt & wrap_mask;
            yt = yt & wrap_mask;
        end
        outside = (xt >= i_cfg.map_size_tiles) || (yt >= i_cfg.map_size_tiles);
    end

    // Byte offset inside a tile: 4 byte rows in 4 bit mode, 8 byte rows otherwise.
    assign sub = i_cfg.four_bit_mode ? {1'b0, i_y_pixel[2:0], i_x_pixel[2:1]}
                                     : {i_y_pixel[2:0], i_x_pixel[2:0]};

    // First read: the map entry, or the pixel byte of tile 0 when clipped.
    assign row_offset = 16'(yt) * 16'(i_cfg.map_size_tiles);
    assign map_sum    = 32'(i_cfg.map_base) + 32'(row_offset) + 32'(xt);
    assign clip_sum   = 32'(i_cfg.tile_base) + 32'(sub);
    assign o_first_addr = outside ? ADDR_BITS'(clip_sum) : ADDR_BITS'(map_sum);

    // Second read: the pixel byte inside the tile named by the map.
    assign tile_offset = i_cfg.four_bit_mode ? {1'b0, i_tile, 5'd0} : {i_tile, 6'd0};
    assign tile_sum    = 32'(i_cfg.tile_base) + 32'(tile_offset) + 32'(i_sub);
    assign o_tile_addr = ADDR_BITS'(tile_sum);

    assign o_plan.outside = outside;
    assign o_plan.sub     = sub;
    assign o_plan.nibble  = outside ? 1'b0 : i_x_pixel[0];

endmodule

`default_nettype wire

// ===== hdl/atf_merge.sv =====
// Write merge: combines the old byte with a nibble-aware or masked write.
`default_nettype none

module atf_merge (
    input  wire atf_pkg::t_cfg  i_cfg,
    input  wire logic [1:0]     i_kind,
    input  wire atf_pkg::t_wreq i_wreq,
    input  wire logic [7:0]     i_old,
    output logic                o_we,
    output logic      [7:0]     o_data
);

    logic [7:0] v;

    assign v = i_wreq.value;

    // Byte merge and transparency decision.
    always_comb begin
        o_we   = 1'b0;
        o_data = v;
        if (i_kind == atf_pkg::KIND_NIBBLE) begin
            if (i_cfg.four_bit_mode) begin
                if (i_wreq.low_nibble) begin
                    o_we   = !i_cfg.transparent_writes || (v[3:0] != 4'd0);
                    o_data = {i_old[7:4], v[3:0]};
                end else begin
                    o_we   = !i_cfg.transparent_writes || (v[7:4] != 4'd0);
                    o_data = {v[7:4], i_old[3:0]};
                end
            end else begin
                o_we = !i_cfg.transparent_writes || (v != 8'd0);
            end
        end else if (i_kind == atf_pkg::KIND_MASKED) begin
            if (!(i_cfg.transparent_writes && (v == 8'd0))) begin
                unique case (i_wreq.mask)
                    atf_pkg::MASK_FULL: begin
                        o_we = 1'b1;
                    end
                    atf_pkg::MASK_HIGH: begin
                        o_we   = 1'b1;
                        o_data = {v[7:4], i_old[3:0]};
                    end
                    atf_pkg::MASK_LOW: begin
                        o_we   = 1'b1;
                        o_data = {i_old[7:4], v[3:0]};
                    end
                    default: begin
                        o_we = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/affine_tile_fetch_vram_writer.sv =====
// Top level of the affine tile fetch unit with nibble-aware and masked video memory writes.
// A clipped fetch reads its pixel byte at acceptance and loads the result word in S_DATA;
// a map fetch reads the map entry first and the pixel byte in S_MAP, as both share one port.
// A new word is taken only in S_IDLE: writes pass S_WR, map fetches S_MAP and S_DATA, and
// clipped fetches S_DATA alone; a fetch outside address mode 3 or kind 3 gives no result.
// Reset (i_rst_n, synchronous, active low) clears the sequencer, the output valid flag, the
// nibble select and the configuration; video memory is not cleared and has no clearing pass.
`default_nettype none

module affine_tile_fetch_vram_writer #(
    parameter int VRAM_ADDR_BITS = 17
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata from bit 0: x_pixel[10:0], y_pixel[10:0], write_address[16:0], low_nibble,
    // write_value[7:0], write_mask[1:0], zero fill.
    input  wire logic [55:0] i_s_axis_tdata,
    // tuser: kind[1:0].
    input  wire logic [1:0]  i_s_axis_tuser,
    // Output stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata from bit 0: fetch_address[16:0], fetch_data[7:0], nibble_select, zero fill.
    output logic      [31:0] o_m_axis_tdata
);

    localparam int A = VRAM_ADDR_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAP  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    atf_pkg::t_cfg  r_cfg;
    atf_pkg::t_plan plan;
    atf_pkg::t_wreq in_wreq;
    atf_pkg::t_wreq r_wreq;

    logic [1:0]   r_state, n_state;
    logic [1:0]   r_kind;
    logic [5:0]   r_sub;
    logic [A-1:0] r_faddr;
    logic [A-1:0] r_waddr;
    logic         r_nibble;
    logic         r_out_valid;
    logic [16:0]  r_out_addr;
    logic [7:0]   r_out_data;
    logic         r_out_nib;

    logic [1:0]   in_kind;
    logic [10:0]  in_x;
    logic [10:0]  in_y;
    logic [A-1:0] in_waddr;
    logic         s_acc;
    logic         is_fetch;
    logic         is_write;
    logic         out_free;
    logic         out_load;
    logic [A-1:0] first_addr;
    logic [A-1:0] tile_addr;
    logic         ram_re;
    logic [A-1:0] ram_raddr;
    logic [7:0]   ram_rdata;
    logic         ram_we;
    logic [7:0]   ram_wdata;
    logic         merge_we;

    // Input word unpacking.
    assign in_kind            = i_s_axis_tuser;
    assign in_x               = i_s_axis_tdata[10:0];
    assign in_y               = i_s_axis_tdata[21:11];
    assign in_waddr           = A'(i_s_axis_tdata[38:22]);
    assign in_wreq.low_nibble = i_s_axis_tdata[39];
    assign in_wreq.value      = i_s_axis_tdata[47:40];
    assign in_wreq.mask       = i_s_axis_tdata[49:48];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_fetch = (in_kind == atf_pkg::KIND_FETCH) &&
                      (r_cfg.address_mode == atf_pkg::ADDR_MODE_AFFINE);
    assign is_write = (in_kind == atf_pkg::KIND_NIBBLE) || (in_kind == atf_pkg::KIND_MASKED);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign out_load = (r_state == S_DATA) && out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_mode       <= 2'd0;
            r_cfg.four_bit_mode      <= 1'b0;
            r_cfg.transparent_writes <= 1'b0;
            r_cfg.affine_clip        <= 1'b0;
            r_cfg.map_size_tiles     <= 8'd2;
            r_cfg.map_base           <= 17'd0;
            r_cfg.tile_base          <= 17'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atf_pkg::CFG_ADDRESS_MODE:       r_cfg.address_mode       <= i_cfg_data[1:0];
                atf_pkg::CFG_FOUR_BIT_MODE:      r_cfg.four_bit_mode      <= i_cfg_data[0];
                atf_pkg::CFG_TRANSPARENT_WRITES: r_cfg.transparent_writes <= i_cfg_data[0];
                atf_pkg::CFG_AFFINE_CLIP:        r_cfg.affine_clip        <= i_cfg_data[0];
                atf_pkg::CFG_MAP_SIZE_TILES:     r_cfg.map_size_tiles     <= i_cfg_data[7:0];
                atf_pkg::CFG_MAP_BASE:           r_cfg.map_base           <= i_cfg_data;
                atf_pkg::CFG_TILE_BASE:          r_cfg.tile_base          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Address computation for both fetch reads.
    atf_addr #(
        .ADDR_BITS (A)
    ) u_addr (
        .i_cfg        (r_cfg),
        .i_x_pixel    (in_x),
        .i_y_pixel    (in_y),
        .i_tile       (ram_rdata),
        .i_sub        (r_sub),
        .o_plan       (plan),
        .o_first_addr (first_addr),
        .o_tile_addr  (tile_addr)
    );

    // Write merge with the byte read back from memory.
    atf_merge u_merge (
        .i_cfg  (r_cfg),
        .i_kind (r_kind),
        .i_wreq (r_wreq),
        .i_old  (ram_rdata),
        .o_we   (merge_we),
        .o_data (ram_wdata)
    );

    // Memory read port selection.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = first_addr;
        if (s_acc && is_fetch) begin
            ram_re = 1'b1;
        end else if (s_acc && is_write) begin
            ram_re    = 1'b1;
            ram_raddr = in_waddr;
        end else if (r_state == S_MAP) begin
            ram_re    = 1'b1;
            ram_raddr = tile_addr;
        end
    end

    assign ram_we = (r_state == S_WR) && merge_we;

    atf_ram #(
        .WIDTH (8),
        .DEPTH (1 << A)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && is_fetch) begin
                    n_state = plan.outside ? S_DATA : S_MAP;
                end else if (s_acc && is_write) begin
                    n_state = S_WR;
                end
            end
            S_MAP: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WR: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nibble    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc && is_fetch && r_cfg.four_bit_mode) begin
                r_nibble <= plan.nibble;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload captured at acceptance; the fetch address follows the second read.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind  <= in_kind;
            r_wreq  <= in_wreq;
            r_waddr <= in_waddr;
            r_sub   <= plan.sub;
            r_faddr <= first_addr;
        end else if (r_state == S_MAP) begin
            r_faddr <= tile_addr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr <= 17'(r_faddr);
            r_out_data <= ram_rdata;
            r_out_nib  <= r_nibble;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_nib, r_out_data, r_out_addr};

    // A map read is always followed by the pixel byte read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |=> (r_state == S_DATA))
        else $error("map read not followed by pixel read");

    // An active fetch always goes on to a memory read state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_fetch) |=> (r_state == S_MAP || r_state == S_DATA))
        else $error("active fetch dropped");

    // A new result word only comes from the pixel read state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DATA) |=> !(r_out_valid && !$past(r_out_valid)))
        else $error("result word without pixel read");

    // Memory is never written and read in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("write overlaps a read");

endmodule

`default_nettype wire
